/* src/fcvd_pkg.sv */
// Shared types, constants and helpers for the face corner vertex dedup block.
package fcvd_pkg;

    localparam int TABLE_DEPTH    = 1024;
    localparam int ADDR_W         = $clog2(TABLE_DEPTH);
    localparam int KEY_FIELD_BITS = 20;
    localparam int MAX_CORNER_IDS = 6;
    localparam int TRI_CORNERS    = 3;
    localparam int QUAD_CORNERS   = 4;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_COUNT = 2'd1,
        ERR_FULL  = 2'd2
    } err_code_t;

    typedef struct packed {
        logic [KEY_FIELD_BITS-1:0] p;
        logic [KEY_FIELD_BITS-1:0] t;
        logic [KEY_FIELD_BITS-1:0] n;
    } triple_t;

    typedef struct packed {
        logic        group_start;
        logic [19:0] pos_index;
        logic [19:0] tex_index;
        logic [19:0] nor_index;
        logic        face_end;
    } in_word_t;

    typedef struct packed {
        logic [9:0]  vertex_index;
        logic        is_new;
        logic [19:0] key_pos;
        logic [19:0] key_tex;
        logic [19:0] key_nor;
        logic        last_of_face;
        logic [1:0]  error_code;
    } out_word_t;

    // triangle corner id -> buffered corner (quad fan 0,1,2,0,2,3)
    function automatic logic [1:0] quad_sel(input logic [2:0] id);
        logic [1:0] r;
        case (id)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd0;
            3'd4:    r = 2'd2;
            3'd5:    r = 2'd3;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

/* src/fcvd_key_store.sv */
// Key store memory: one write port, one registered read port.
module fcvd_key_store (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [fcvd_pkg::ADDR_W-1:0] waddr,
    input  fcvd_pkg::triple_t           wdata,
    input  logic [fcvd_pkg::ADDR_W-1:0] raddr,
    output fcvd_pkg::triple_t           rdata
);
    fcvd_pkg::triple_t mem [fcvd_pkg::TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/face_corner_vertex_dedup_core.sv */
// Top level of the face corner vertex dedup block.
//
//  channel | dir | word       | handshake
//  s_      | in  | in_word_t  | s_valid / s_ready, one corner per word
//  m_      | out | out_word_t | m_valid / m_ready, one triangle corner per word
//
// A corner that is not a face end gives no output word. At a face end each of the
// 3 or 6 triangle corners scans the key store over its single read port, one
// entry at a time from entry 0 (read, compare), until a hit or the last filled
// entry; a new triple is a miss at once when the store is empty.
// Reset is synchronous, active low; entries below the fill count are the valid
// ones, so no sweep. s_ready is low during lookup or while a word waits on m_.
module face_corner_vertex_dedup_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fcvd_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fcvd_pkg::out_word_t m_data
);
    localparam int AW = fcvd_pkg::ADDR_W;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CMP, ST_WAIT} state_t;

    state_t              state_reg, state_next;
    logic [2:0]          count_reg, count_next;  // saturates at 5 = more than four
    fcvd_pkg::triple_t   buf_reg [4];
    logic                err_reg, err_next;
    logic [AW:0]         nidx_reg, nidx_next;    // fill count, also next vertex index
    logic [2:0]          cid_reg, cid_next;      // triangle corner id within face
    logic                quad_reg, quad_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic                done_reg, done_next;    // face finished after this word
    logic                m_valid_reg, m_valid_next;
    fcvd_pkg::out_word_t m_data_reg, m_data_next;

    fcvd_pkg::triple_t   cur;
    fcvd_pkg::triple_t   rd_data;
    fcvd_pkg::triple_t   in_tri;
    logic                match, last_entry, hit, miss, full, last_corner, wr_en;
    logic                gs, err_eff, buf_we;
    logic [2:0]          cnt_eff, cnt_inc;
    logic [AW:0]         nidx_eff;

    assign cur         = buf_reg[fcvd_pkg::quad_sel(cid_reg)];
    assign match       = (rd_data == cur);
    assign last_entry  = ({1'b0, addr_reg} + 1'b1) == nidx_reg;
    assign hit         = (state_reg == ST_CMP) && match;
    assign miss        = ((state_reg == ST_READ) && (nidx_reg == '0))
                      || ((state_reg == ST_CMP) && !match && last_entry);
    assign full        = nidx_reg[AW];
    assign wr_en       = miss && !full;
    assign last_corner = quad_reg ? (cid_reg == 3'(fcvd_pkg::MAX_CORNER_IDS - 1))
                                  : (cid_reg == 3'(fcvd_pkg::TRI_CORNERS - 1));

    assign gs       = s_data.group_start;
    assign err_eff  = gs ? 1'b0 : err_reg;
    assign cnt_eff  = gs ? 3'd0 : count_reg;
    assign nidx_eff = gs ? '0 : nidx_reg;
    assign cnt_inc  = (cnt_eff < 3'(fcvd_pkg::QUAD_CORNERS)) ? cnt_eff + 3'd1 : 3'd5;
    assign in_tri   = '{p: s_data.pos_index, t: s_data.tex_index, n: s_data.nor_index};

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    fcvd_key_store u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (nidx_reg[AW-1:0]),
        .wdata (cur),
        .raddr (addr_reg),
        .rdata (rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        nidx_next    = nidx_reg;
        cid_next     = cid_reg;
        quad_next    = quad_reg;
        addr_next    = addr_reg;
        done_next    = done_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        buf_we       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    err_next   = err_eff;
                    nidx_next  = nidx_eff;
                    count_next = cnt_eff;
                    if (!err_eff) begin
                        count_next = cnt_inc;
                        buf_we     = (cnt_eff < 3'(fcvd_pkg::QUAD_CORNERS));
                        if (s_data.face_end) begin
                            count_next = '0;
                            if (cnt_inc == 3'(fcvd_pkg::TRI_CORNERS) ||
                                cnt_inc == 3'(fcvd_pkg::QUAD_CORNERS)) begin
                                quad_next  = (cnt_inc == 3'(fcvd_pkg::QUAD_CORNERS));
                                cid_next   = '0;
                                addr_next  = '0;
                                state_next = ST_READ;
                            end else begin
                                // bad corner count: one error word
                                err_next                 = 1'b1;
                                m_data_next              = '0;
                                m_data_next.last_of_face = 1'b1;
                                m_data_next.error_code   = fcvd_pkg::ERR_COUNT;
                                m_valid_next             = 1'b1;
                                done_next                = 1'b1;
                                state_next               = ST_WAIT;
                            end
                        end
                    end
                end
            end
            ST_READ: begin
                if (!miss) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (!match && !last_entry) begin
                    addr_next  = addr_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_WAIT: begin
                if (m_ready) begin
                    addr_next  = '0;
                    cid_next   = cid_reg + 3'd1;
                    state_next = done_reg ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // result of one lookup
        if (hit || miss) begin
            m_data_next.key_pos = cur.p;
            m_data_next.key_tex = cur.t;
            m_data_next.key_nor = cur.n;
            m_valid_next        = 1'b1;
            state_next          = ST_WAIT;
            if (hit) begin
                m_data_next.vertex_index = addr_reg;
                m_data_next.is_new       = 1'b0;
                m_data_next.last_of_face = last_corner;
                m_data_next.error_code   = fcvd_pkg::ERR_OK;
                done_next                = last_corner;
            end else if (full) begin
                m_data_next.vertex_index = '0;
                m_data_next.is_new       = 1'b0;
                m_data_next.last_of_face = 1'b1;
                m_data_next.error_code   = fcvd_pkg::ERR_FULL;
                err_next                 = 1'b1;
                done_next                = 1'b1;
            end else begin
                m_data_next.vertex_index = nidx_reg[AW-1:0];
                m_data_next.is_new       = 1'b1;
                m_data_next.last_of_face = last_corner;
                m_data_next.error_code   = fcvd_pkg::ERR_OK;
                nidx_next                = nidx_reg + 1'b1;
                done_next                = last_corner;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            err_reg     <= 1'b0;
            nidx_reg    <= '0;
            cid_reg     <= '0;
            quad_reg    <= 1'b0;
            addr_reg    <= '0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
            nidx_reg    <= nidx_next;
            cid_reg     <= cid_next;
            quad_reg    <= quad_next;
            addr_reg    <= addr_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
            if (buf_we) begin
                buf_reg[cnt_eff[1:0]] <= in_tri;
            end
        end
    end
endmodule

/* src/fcvd_checker.sv */
// Port-level checks for the face corner vertex dedup core, bound to the top.
module fcvd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input fcvd_pkg::in_word_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input fcvd_pkg::out_word_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word dropped or changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input taken while a result word is pending");

    a_cnt_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code == fcvd_pkg::ERR_COUNT
        |-> m_data.last_of_face && m_data.vertex_index == '0 && m_data.key_pos == '0)
        else $error("corner count error word malformed");

    a_err_new: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code != fcvd_pkg::ERR_OK
        |-> !m_data.is_new && m_data.last_of_face)
        else $error("error word flagged new or not last");
endmodule

bind face_corner_vertex_dedup_core fcvd_checker u_fcvd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
